// ===== hw/rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared widths, operation codes and controller/datapath handoff types for
// the trie word store.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int KindW   = 2;
   localparam int LetterW = 5;

   localparam logic [KindW-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KindW-1:0] KIND_SEARCH   = 2'd1;
   localparam logic [KindW-1:0] KIND_PREFIX   = 2'd2;
   localparam logic [KindW-1:0] KIND_RESERVED = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // zero one link slot (and one end mark, while the slot index is below NODES)
      logic start;       // take a request, set up the word, issue the link read
      logic resolve;     // follow or allocate the child link just read
      logic finish;      // close the word and load the response
   } tws_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;  // current clear step is the final one
      logic lookup;      // the request being taken issued a link read
      logic req_last;    // the request being taken ends its word
      logic word_last;   // the word under lookup ends with this letter
   } tws_status_type;

endpackage

// ===== hw/rtl/tws_req_if.sv =====
// ----------------------------------------------------------------------------
// tws_req_if
// Request channel: one letter of a word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tws_req_if import tws_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [KindW-1:0]   kind;
   logic [LetterW-1:0] letter;
   logic               last_letter;
   logic               empty_word;

   modport source (output valid, output kind, output letter, output last_letter,
                   output empty_word, input ready);
   modport sink   (input valid, input kind, input letter, input last_letter,
                   input empty_word, output ready);

endinterface

// ===== hw/rtl/tws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tws_rsp_if
// Response channel: one answer per finished word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tws_rsp_if import tws_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [KindW-1:0] answer_kind;
   logic             hit;
   logic             out_of_nodes;

   modport source (output valid, output answer_kind, output hit, output out_of_nodes,
                   input ready);
   modport sink   (input valid, input answer_kind, input hit, input out_of_nodes,
                   output ready);

endinterface

// ===== hw/rtl/tws_ram.sv =====
// ----------------------------------------------------------------------------
// tws_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tws_datapath.sv =====
// ----------------------------------------------------------------------------
// tws_datapath
// Node pool, child link store, end marks, word cursor and response
// registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module tws_datapath import tws_pkg::*; #(
   parameter int NODES    = 256,
   parameter int ALPHABET = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  tws_cmd_type        cmd,
   output tws_status_type     status,
   input  logic [KindW-1:0]   req_kind,
   input  logic [LetterW-1:0] req_letter,
   input  logic               req_last_letter,
   input  logic               req_empty_word,
   output logic [KindW-1:0]   rsp_answer_kind,
   output logic               rsp_hit,
   output logic               rsp_out_of_nodes
);

   localparam int NodeW   = $clog2(NODES);
   localparam int UsedW   = $clog2(NODES + 1);
   localparam int SlotCnt = NODES * ALPHABET;
   localparam int SlotW   = $clog2(SlotCnt);
   localparam int AlphaW  = $clog2(ALPHABET + 1);
   localparam int CmpW    = (AlphaW > LetterW) ? AlphaW : LetterW;

   logic [NodeW-1:0] cursor_ff, cursor_in;
   logic [UsedW-1:0] used_ff, used_in;
   logic             missed_ff, missed_in;
   logic             mid_ff, mid_in;
   logic [KindW-1:0] kind_ff, kind_in;
   logic             ovf_ff, ovf_in;
   logic             last_ff, last_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [SlotW-1:0] clr_ff, clr_in;

   logic [KindW-1:0] ans_kind_ff;
   logic             ans_hit_ff;
   logic             ans_oon_ff;
   logic             ans_hit;

   logic [KindW-1:0] req_kind_sat;
   logic             letter_oor;
   logic             lookup;

   logic             link_we;
   logic [SlotW-1:0] link_waddr;
   logic [NodeW-1:0] link_wdata;
   logic [NodeW-1:0] link_rdata;
   logic             mark_we;
   logic [NodeW-1:0] mark_waddr;
   logic             mark_wdata;
   logic             mark_re;
   logic             mark_rdata;

   tws_ram #(.WIDTH(NodeW), .DEPTH(SlotCnt)) u_links (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (cmd.start),
      .raddr (slot_in),
      .rdata (link_rdata)
   );

   tws_ram #(.WIDTH(1), .DEPTH(NODES)) u_marks (
      .clock (clock),
      .we    (mark_we),
      .waddr (mark_waddr),
      .wdata (mark_wdata),
      .re    (mark_re),
      .raddr (cursor_in),
      .rdata (mark_rdata)
   );

   // kind three is taken as a prefix test
   assign req_kind_sat = (req_kind == KIND_RESERVED) ? KIND_PREFIX : req_kind;
   assign letter_oor   = (CmpW'(req_letter) >= CmpW'(ALPHABET));

   always_comb begin
      cursor_in  = cursor_ff;
      used_in    = used_ff;
      missed_in  = missed_ff;
      mid_in     = mid_ff;
      kind_in    = kind_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      slot_in    = slot_ff;
      clr_in     = clr_ff;
      lookup     = 1'b0;
      link_we    = 1'b0;
      link_waddr = clr_ff;
      link_wdata = '0;
      mark_we    = 1'b0;
      mark_waddr = clr_ff[NodeW-1:0];
      mark_wdata = 1'b0;
      mark_re    = 1'b0;

      if (cmd.clear_step) begin
         link_we = 1'b1;
         mark_we = (clr_ff < SlotW'(NODES));
         clr_in  = clr_ff + 1'b1;
      end

      if (cmd.start) begin
         mark_re = 1'b1;
         last_in = req_empty_word | req_last_letter;
         if (req_empty_word) begin
            // abandon any partial word and act on the root
            kind_in   = req_kind_sat;
            cursor_in = '0;
            missed_in = 1'b0;
            ovf_in    = 1'b0;
            mid_in    = 1'b0;
         end else begin
            if (!mid_ff) begin
               kind_in   = req_kind_sat;
               cursor_in = '0;
               missed_in = 1'b0;
               ovf_in    = 1'b0;
            end
            mid_in = 1'b1;
            if (!missed_in) begin
               if (letter_oor) begin
                  // insert skips the letter, lookups miss
                  if (kind_in != KIND_INSERT) begin
                     missed_in = 1'b1;
                  end
               end else begin
                  lookup  = 1'b1;
                  slot_in = SlotW'(cursor_in) * SlotW'(ALPHABET) + SlotW'(req_letter);
               end
            end
         end
      end

      if (cmd.resolve) begin
         mark_re = 1'b1;
         if (link_rdata != '0) begin
            cursor_in = link_rdata;
         end else if (kind_ff != KIND_INSERT) begin
            missed_in = 1'b1;
         end else if (used_ff >= UsedW'(NODES)) begin
            ovf_in    = 1'b1;
            missed_in = 1'b1;
         end else begin
            // allocate the next free node and link it in
            link_we    = 1'b1;
            link_waddr = slot_ff;
            link_wdata = used_ff[NodeW-1:0];
            cursor_in  = used_ff[NodeW-1:0];
            used_in    = used_ff + 1'b1;
         end
      end

      if (cmd.finish) begin
         mark_we    = (kind_ff == KIND_INSERT) && !missed_ff;
         mark_waddr = cursor_ff;
         mark_wdata = 1'b1;
         mid_in     = 1'b0;
         cursor_in  = '0;
         missed_in  = 1'b0;
         ovf_in     = 1'b0;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_INSERT: ans_hit = 1'b1;
         KIND_SEARCH: ans_hit = !missed_ff && mark_rdata;
         default:     ans_hit = !missed_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         used_ff   <= UsedW'(1);
         missed_ff <= 1'b0;
         mid_ff    <= 1'b0;
         kind_ff   <= KIND_INSERT;
         ovf_ff    <= 1'b0;
         last_ff   <= 1'b0;
         clr_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         used_ff   <= used_in;
         missed_ff <= missed_in;
         mid_ff    <= mid_in;
         kind_ff   <= kind_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
         clr_ff    <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.finish) begin
         ans_kind_ff <= kind_ff;
         ans_hit_ff  <= ans_hit;
         ans_oon_ff  <= (kind_ff == KIND_INSERT) && ovf_ff;
      end
   end

   assign status.clear_done = (clr_ff == SlotW'(SlotCnt - 1));
   assign status.lookup     = lookup;
   assign status.req_last   = req_empty_word | req_last_letter;
   assign status.word_last  = last_ff;

   assign rsp_answer_kind  = ans_kind_ff;
   assign rsp_hit          = ans_hit_ff;
   assign rsp_out_of_nodes = ans_oon_ff;

endmodule

// ===== hw/rtl/tws_ctrl.sv =====
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer: clear pass after reset, then request intake, link lookup and
// response handoff.
// ----------------------------------------------------------------------------
module tws_ctrl import tws_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  tws_status_type status,
   output tws_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.start      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.resolve    = (state_ff == ST_LOOKUP);
   assign cmd.finish     = (state_ff == ST_OUT) && slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  if (status.lookup) begin
                     state_ff <= ST_LOOKUP;
                  end else if (status.req_last) begin
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_LOOKUP: begin
               state_ff <= status.word_last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
               // hold until the response register is free
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/trie_word_store_core.sv =====
// ----------------------------------------------------------------------------
// trie_word_store_core
// Prefix tree store over a letter alphabet: insert, exact search and prefix
// test, one letter per request, one response per finished word.
// ----------------------------------------------------------------------------
// Sequence: a letter is taken at intake, then its child link is read from the
//   link RAM; intake alone once the word has missed or for a skipped letter.
// A word's last letter then loads the response register, held while it is full.
// Intake: a new letter is not taken until the previous one is through.
// Reset: a clear pass zeroes all NODES*ALPHABET link slots and the end marks;
//   no request is taken until it completes.
module trie_word_store_core import tws_pkg::*; #(
   parameter int NODES    = 256,
   parameter int ALPHABET = 26
) (
   input logic      clock,
   input logic      reset,
   tws_req_if.sink  req_chan,
   tws_rsp_if.source rsp_chan
);

   tws_cmd_type    cmd;
   tws_status_type status;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tws_datapath #(.NODES(NODES), .ALPHABET(ALPHABET)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_chan.kind),
      .req_letter       (req_chan.letter),
      .req_last_letter  (req_chan.last_letter),
      .req_empty_word   (req_chan.empty_word),
      .rsp_answer_kind  (rsp_chan.answer_kind),
      .rsp_hit          (rsp_chan.hit),
      .rsp_out_of_nodes (rsp_chan.out_of_nodes)
   );

endmodule

// ===== tb/sv/trie_word_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_word_store_core_tb
// Self-checking bench for the trie word store. Letter requests go in through
// the request channel; a behavioral trie in the bench predicts each word's
// answer, and a monitor compares every response in order. Runs directed
// corner cases, random vocabulary traffic under several idle/stall mixes, a
// response hold-off that backs up the input, and a pass that drains the pool.
// ----------------------------------------------------------------------------
module trie_word_store_core_tb import tws_pkg::*; ();

   localparam int TRIE_NODES    = 256;
   localparam int TRIE_LETTERS  = 26;
   localparam int LETTER_MAX    = (1 << LetterW) - 1;
   localparam int VOCAB_WORDS   = 20;
   localparam int VOCAB_MAX_LEN = 5;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [KindW-1:0] answer_kind;
      logic             hit;
      logic             out_of_nodes;
   } word_answer_type;

   logic clock = 1'b0;
   logic reset;

   tws_req_if req_if ();
   tws_rsp_if rsp_if ();

   trie_word_store_core #(
      .NODES   (TRIE_NODES),
      .ALPHABET(TRIE_LETTERS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always #5 clock = ~clock;

   // behavioral trie
   int               next_node_of [TRIE_NODES*TRIE_LETTERS];
   bit               is_word_end [TRIE_NODES];
   int               alloc_count = 1;
   int               walk_node   = 0;
   bit               walk_failed = 1'b0;
   bit               in_word     = 1'b0;
   bit               ran_dry     = 1'b0;
   logic [KindW-1:0] open_kind   = KIND_INSERT;

   word_answer_type pending_answers[$];

   int req_idle_pct    = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_left   = 0;
   int requests_sent   = 0;
   int answers_checked = 0;
   int fail_count      = 0;

   logic [LetterW-1:0] vocab_letter [VOCAB_WORDS][VOCAB_MAX_LEN];
   int                 vocab_len [VOCAB_WORDS];

   function automatic void reset_walk();
      in_word     = 1'b0;
      walk_node   = 0;
      walk_failed = 1'b0;
      ran_dry     = 1'b0;
   endfunction

   function automatic void descend(logic [LetterW-1:0] letter);
      int slot;
      int child;
      if (walk_failed) return;
      if (letter >= TRIE_LETTERS) begin
         // insert skips the letter, lookups miss
         if (open_kind != KIND_INSERT) walk_failed = 1'b1;
         return;
      end
      slot  = walk_node * TRIE_LETTERS + letter;
      child = next_node_of[slot];
      if (child == 0) begin
         if (open_kind != KIND_INSERT) begin
            walk_failed = 1'b1;
            return;
         end
         if (alloc_count >= TRIE_NODES) begin
            ran_dry     = 1'b1;
            walk_failed = 1'b1;
            return;
         end
         child = alloc_count;
         alloc_count++;
         next_node_of[slot] = child;
         is_word_end[child] = 1'b0;
      end
      walk_node = child;
   endfunction

   function automatic void answer_word();
      word_answer_type ans;
      ans.answer_kind  = open_kind;
      ans.out_of_nodes = 1'b0;
      if (open_kind == KIND_INSERT) begin
         if (!walk_failed) is_word_end[walk_node] = 1'b1;
         ans.hit          = 1'b1;
         ans.out_of_nodes = ran_dry;
      end else if (open_kind == KIND_SEARCH) begin
         ans.hit = !walk_failed && is_word_end[walk_node];
      end else begin
         ans.hit = !walk_failed;
      end
      pending_answers.insert(pending_answers.size(), ans);
   endfunction

   function automatic void step_trie(logic [KindW-1:0] kind_in, logic [LetterW-1:0] letter,
                                     logic last, logic empty);
      logic [KindW-1:0] kind;
      kind = (kind_in == KIND_RESERVED) ? KIND_PREFIX : kind_in;
      if (empty) begin
         // an empty word abandons any open word and acts on the root
         reset_walk();
         open_kind = kind;
         answer_word();
         reset_walk();
         return;
      end
      if (!in_word) begin
         open_kind   = kind;
         walk_node   = 0;
         walk_failed = 1'b0;
         ran_dry     = 1'b0;
         in_word     = 1'b1;
      end
      descend(letter);
      if (last) begin
         answer_word();
         reset_walk();
      end
   endfunction

   function automatic logic [KindW-1:0] pick_kind();
      if ($urandom_range(19) == 0) return KIND_RESERVED;
      return KindW'($urandom_range(KIND_INSERT, KIND_PREFIX));
   endfunction

   // called and returning at a rising edge; valid stays up after the handshake
   task automatic send_request(input logic [KindW-1:0] kind, input logic [LetterW-1:0] letter,
                               input logic last, input logic empty);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.letter      <= letter;
      req_if.last_letter <= last;
      req_if.empty_word  <= empty;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
      step_trie(kind, letter, last, empty);
   endtask

   task automatic await_idle();
      req_if.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_word();
      int                 pick;
      int                 w;
      int                 len;
      logic [KindW-1:0]   kind;
      logic [LetterW-1:0] letter;
      pick = $urandom_range(99);
      kind = pick_kind();
      if (pick < 75) begin
         // well-formed vocabulary word, sometimes cut short or with a bad letter
         w   = $urandom_range(VOCAB_WORDS - 1);
         len = vocab_len[w];
         if ($urandom_range(3) == 0) len = $urandom_range(1, len);
         for (int i = 0; i < len; i++) begin
            letter = vocab_letter[w][i];
            // inserts only see a bad letter at the end so no stray nodes grow
            if ($urandom_range(19) == 0 && (kind != KIND_INSERT || i == len - 1))
               letter = LetterW'($urandom_range(TRIE_LETTERS, LETTER_MAX));
            else if ($urandom_range(19) == 0 && kind != KIND_INSERT)
               letter = LetterW'($urandom_range(TRIE_LETTERS - 1));
            send_request((i == 0) ? kind : pick_kind(), letter, i == len - 1, 1'b0);
         end
      end else if (pick < 85) begin
         send_request(kind, LetterW'($urandom_range(LETTER_MAX)), 1'($urandom_range(1)),
                      1'b1);
      end else if (pick < 93) begin
         // lookups of random letters, out-of-range ones included
         kind = ($urandom_range(3) == 0) ? KIND_RESERVED
                                         : KindW'($urandom_range(KIND_SEARCH, KIND_PREFIX));
         len  = $urandom_range(1, 4);
         for (int i = 0; i < len; i++)
            send_request((i == 0) ? kind : pick_kind(), LetterW'($urandom_range(LETTER_MAX)),
                         i == len - 1, 1'b0);
      end else begin
         // partial word cut off by an empty word
         w   = $urandom_range(VOCAB_WORDS - 1);
         len = $urandom_range(1, vocab_len[w]);
         for (int i = 0; i < len; i++)
            send_request((i == 0) ? kind : pick_kind(), vocab_letter[w][i], 1'b0, 1'b0);
         send_request(pick_kind(), LetterW'($urandom_range(LETTER_MAX)),
                      1'($urandom_range(1)), 1'b1);
      end
   endtask

   task automatic test_directed_cases();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // empty words act on the root
      send_request(KIND_SEARCH, 5'd0, 1'b0, 1'b1);
      send_request(KIND_PREFIX, LetterW'(LETTER_MAX), 1'b1, 1'b1);
      send_request(KIND_INSERT, 5'd7, 1'b0, 1'b1);
      send_request(KIND_RESERVED, 5'd0, 1'b1, 1'b1);
      send_request(KIND_SEARCH, 5'd0, 1'b1, 1'b1);
      // first and last letter of the alphabet
      send_request(KIND_INSERT, 5'd0, 1'b1, 1'b0);
      send_request(KIND_INSERT, 5'd25, 1'b1, 1'b0);
      // insert skips an out-of-range letter; kinds after the first are ignored
      send_request(KIND_INSERT, 5'd1, 1'b0, 1'b0);
      send_request(KIND_RESERVED, LetterW'(LETTER_MAX), 1'b0, 1'b0);
      send_request(KIND_SEARCH, 5'd2, 1'b1, 1'b0);
      send_request(KIND_SEARCH, 5'd0, 1'b1, 1'b0);
      send_request(KIND_SEARCH, 5'd1, 1'b0, 1'b0);
      send_request(KIND_INSERT, 5'd2, 1'b1, 1'b0);
      // lookup through an out-of-range letter misses
      send_request(KIND_SEARCH, 5'd1, 1'b0, 1'b0);
      send_request(KIND_PREFIX, 5'd26, 1'b1, 1'b0);
      send_request(KIND_PREFIX, 5'd1, 1'b1, 1'b0);
      send_request(KIND_RESERVED, 5'd25, 1'b1, 1'b0);
      send_request(KIND_PREFIX, 5'd16, 1'b1, 1'b0);
      // path exists but is not a stored word
      send_request(KIND_SEARCH, 5'd1, 1'b1, 1'b0);
      // partial insert dropped by an empty word keeps its nodes
      send_request(KIND_INSERT, 5'd24, 1'b0, 1'b0);
      send_request(KIND_INSERT, 5'd23, 1'b0, 1'b0);
      send_request(KIND_SEARCH, 5'd0, 1'b0, 1'b1);
      send_request(KIND_PREFIX, 5'd24, 1'b0, 1'b0);
      send_request(KIND_SEARCH, 5'd23, 1'b1, 1'b0);
      await_idle();
   endtask

   task automatic test_random_traffic(input int n_requests, input int idle_pct,
                                      input int stall_pct);
      int first_request;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      first_request = requests_sent;
      while (requests_sent - first_request < n_requests) begin
         send_random_word();
         if ($urandom_range(99) == 0) await_idle();
      end
      await_idle();
   endtask

   // hold the response side off while requests keep coming
   task automatic test_backpressure_fill();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 300;
      for (int i = 0; i < 30; i++)
         send_request(pick_kind(), LetterW'($urandom_range(TRIE_LETTERS - 1)), 1'b1, 1'b0);
      await_idle();
   endtask

   // long random inserts until the pool is gone, each followed by a lookup
   task automatic test_pool_exhaustion();
      logic [LetterW-1:0] letters [14];
      int                 len;
      int                 words_after_full;
      logic [KindW-1:0]   kind;
      req_idle_pct     = 20;
      rsp_stall_pct    = 20;
      words_after_full = 0;
      while (words_after_full < 6) begin
         if (alloc_count >= TRIE_NODES) words_after_full++;
         len = $urandom_range(6, 14);
         for (int i = 0; i < len; i++) letters[i] = LetterW'($urandom_range(TRIE_LETTERS - 1));
         for (int i = 0; i < len; i++)
            send_request((i == 0) ? KIND_INSERT : pick_kind(), letters[i], i == len - 1, 1'b0);
         kind = KindW'($urandom_range(KIND_SEARCH, KIND_PREFIX));
         for (int i = 0; i < len; i++)
            send_request((i == 0) ? kind : pick_kind(), letters[i], i == len - 1, 1'b0);
      end
      await_idle();
   endtask

   // response monitor and ready driver
   initial begin
      word_answer_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            answers_checked++;
            if (pending_answers.size() == 0) begin
               $error("response with no word outstanding: kind %0d hit %0d out_of_nodes %0d",
                      rsp_if.answer_kind, rsp_if.hit, rsp_if.out_of_nodes);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_if.answer_kind !== want.answer_kind) begin
                  $error("answer_kind: expected %0d, got %0d", want.answer_kind,
                         rsp_if.answer_kind);
                  fail_count++;
               end
               if (rsp_if.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
                  fail_count++;
               end
               if (rsp_if.out_of_nodes !== want.out_of_nodes) begin
                  $error("out_of_nodes: expected %0d, got %0d", want.out_of_nodes,
                         rsp_if.out_of_nodes);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.kind        <= KIND_INSERT;
      req_if.letter      <= '0;
      req_if.last_letter <= 1'b0;
      req_if.empty_word  <= 1'b0;
      for (int w = 0; w < VOCAB_WORDS; w++) begin
         vocab_len[w] = $urandom_range(1, VOCAB_MAX_LEN);
         for (int i = 0; i < VOCAB_MAX_LEN; i++)
            vocab_letter[w][i] = ($urandom_range(9) == 0) ? 5'd25
                                                          : LetterW'($urandom_range(9));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(230, 0, 0);
      test_random_traffic(230, 56, 0);
      test_random_traffic(230, 0, 56);
      test_random_traffic(230, 33, 33);
      test_backpressure_fill();
      test_pool_exhaustion();
      test_random_traffic(60, 33, 33);

      $display("Checked %0d answers over %0d letter requests, directed, random and stalled",
               answers_checked, requests_sent);
      $display("Trie pool ended with %0d of %0d nodes in use", alloc_count, TRIE_NODES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
